FILE: rtl/core/csk_pkg.sv
// Shared constants and types for the soft knee compander transfer curve.
`timescale 1ns / 1ps
`default_nettype none

package csk_pkg;

	localparam int MAX_POINTS = 8;
	localparam logic [13:0] KNEE_MIN = 14'd26;
	localparam logic [13:0] KNEE_NARROW = 14'd2;

	localparam int NUM_W = 64;
	localparam int MAG_W = 63;
	localparam int DEN_W = 49;
	localparam int QUO_W = 32;

	typedef enum logic [2:0] {
		CFG_POINT_COUNT = 3'd0,
		CFG_KNEE_WIDTH  = 3'd1,
		CFG_PAIR_01     = 3'd2,
		CFG_PAIR_23     = 3'd3,
		CFG_PAIR_45     = 3'd4,
		CFG_PAIR_67     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] base;
		logic               neg;
	} div_side_t;

endpackage

`default_nettype wire

FILE: rtl/core/csk_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module csk_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [csk_pkg::MAG_W-1:0]     mag,
	input  wire logic [csk_pkg::DEN_W-1:0]     den,
	input  wire csk_pkg::div_side_t            side_in,
	output logic                               out_valid,
	output logic [csk_pkg::QUO_W-1:0]          quo,
	output logic                               rem_nz,
	output csk_pkg::div_side_t                 side_out
);

	logic                         vld_s  [0:csk_pkg::QUO_W];
	logic [csk_pkg::DEN_W-1:0]    rem_s  [0:csk_pkg::QUO_W];
	logic [csk_pkg::DEN_W-1:0]    den_s  [0:csk_pkg::QUO_W];
	logic [csk_pkg::QUO_W-1:0]    lo_s   [0:csk_pkg::QUO_W];
	logic [csk_pkg::QUO_W-1:0]    quo_s  [0:csk_pkg::QUO_W];
	csk_pkg::div_side_t           side_s [0:csk_pkg::QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= csk_pkg::DEN_W'(mag[csk_pkg::MAG_W-1:csk_pkg::QUO_W]);
			lo_s[0]   <= mag[csk_pkg::QUO_W-1:0];
			quo_s[0]  <= '0;
			den_s[0]  <= den;
			side_s[0] <= side_in;
		end
	end

	for (genvar g = 1; g <= csk_pkg::QUO_W; g++) begin : g_stage
		logic [csk_pkg::DEN_W:0] trial;
		logic [csk_pkg::DEN_W:0] diff;
		logic                    take;

		always_comb begin
			trial = {rem_s[g-1], lo_s[g-1][csk_pkg::QUO_W-1]};
			diff  = trial - {1'b0, den_s[g-1]};
			take  = trial >= {1'b0, den_s[g-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= take ? diff[csk_pkg::DEN_W-1:0] : trial[csk_pkg::DEN_W-1:0];
				lo_s[g]   <= {lo_s[g-1][csk_pkg::QUO_W-2:0], 1'b0};
				quo_s[g]  <= {quo_s[g-1][csk_pkg::QUO_W-2:0], take};
				den_s[g]  <= den_s[g-1];
				side_s[g] <= side_s[g-1];
			end
		end
	end

	assign out_valid = vld_s[csk_pkg::QUO_W];
	assign quo       = quo_s[csk_pkg::QUO_W];
	assign rem_nz    = |rem_s[csk_pkg::QUO_W];
	assign side_out  = side_s[csk_pkg::QUO_W];

endmodule

`default_nettype wire

FILE: rtl/core/compander_soft_knee_transfer.sv
// Top level of the compander transfer curve with quadratic soft knee.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output word is stalled. The 32-stage divider sets the depth.
// Reset clears the valid bits and all configuration registers, so the curve
// starts as a pass-through.
`timescale 1ns / 1ps
`default_nettype none

module compander_soft_knee_transfer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] input_level,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      output_level,
	output logic                    saturated
);

	logic [3:0]  pcount_q;
	logic [13:0] knee_q;
	logic [63:0] pair_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= '0;
			knee_q   <= '0;
			for (int i = 0; i < 4; i++) pair_q[i] <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				csk_pkg::CFG_POINT_COUNT: pcount_q <= cfg_data[3:0];
				csk_pkg::CFG_KNEE_WIDTH:  knee_q <= cfg_data[13:0];
				csk_pkg::CFG_PAIR_01:     pair_q[0] <= cfg_data;
				csk_pkg::CFG_PAIR_23:     pair_q[1] <= cfg_data;
				csk_pkg::CFG_PAIR_45:     pair_q[2] <= cfg_data;
				csk_pkg::CFG_PAIR_67:     pair_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [16:0] px17 [8];
	logic signed [15:0] py16 [8];
	logic [3:0]         npts;

	for (genvar g = 0; g < 8; g++) begin : g_pt
		assign px17[g] = $signed({pair_q[g/2][(g%2)*32+15], pair_q[g/2][(g%2)*32 +: 16]});
		assign py16[g] = $signed(pair_q[g/2][(g%2)*32+16 +: 16]);
	end

	assign npts = (pcount_q > 4'(csk_pkg::MAX_POINTS)) ? 4'(csk_pkg::MAX_POINTS) : pcount_q;

	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// Stage 1: input register.
	logic               v_s1;
	logic signed [15:0] x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) x_s1 <= input_level;
	end

	// Stage 1 logic: knee zones for the interior points and segment compares for every point.
	logic [13:0]        ah_c  [1:6];
	logic               hit_c [1:6];
	logic [7:0]         ge_c, le_c;
	logic signed [16:0] x17_s1;

	assign x17_s1 = {x_s1[15], x_s1};

	always_comb begin
		logic signed [16:0] d1, d2, m, u;
		logic signed [17:0] u2, ah18;
		for (int i = 1; i <= 6; i++) begin
			d1 = px17[i] - px17[i-1];
			d2 = px17[i+1] - px17[i];
			m  = $signed({3'b000, knee_q});
			if (d1 < m) m = d1;
			if (d2 < m) m = d2;
			if (m < 0) m = '0;
			ah_c[i]  = m[13:0];
			u        = x17_s1 - px17[i];
			u2       = {u, 1'b0};
			ah18     = $signed({4'b0000, m[13:0]});
			hit_c[i] = (4'(i + 1) < npts) && (u2 >= -ah18) && (u2 <= ah18);
		end
		for (int i = 0; i < 8; i++) begin
			ge_c[i] = x17_s1 >= px17[i];
			le_c[i] = x17_s1 <= px17[i];
		end
	end

	logic               v_s2;
	logic signed [15:0] x_s2;
	logic [13:0]        ah_s2  [1:6];
	logic               hit_s2 [1:6];
	logic [7:0]         ge_s2, le_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2   <= x_s1;
			ah_s2  <= ah_c;
			hit_s2 <= hit_c;
			ge_s2  <= ge_c;
			le_s2  <= le_c;
		end
	end

	// Stage 2 logic: pick the rule and gather its operands.
	logic               knee_c;
	logic signed [15:0] base_c;
	logic signed [16:0] a_c, b_c, d_c, e1_c, e2_c;
	logic [15:0]        d1_c, d2_c;
	logic [14:0]        v_c, w_c;
	logic [13:0]        ahk_c;

	always_comb begin
		logic               found, sfound;
		logic [2:0]         k, sj, nm1, nm2;
		logic signed [16:0] x17, u, dd;
		logic signed [18:0] vt, wt;
		logic [13:0]        ahk;
		found  = 1'b0;
		sfound = 1'b0;
		k      = 3'd1;
		sj     = 3'd0;
		x17    = {x_s2[15], x_s2};
		nm1    = 3'(npts - 4'd1);
		nm2    = 3'(npts - 4'd2);
		for (int i = 1; i <= 6; i++) begin
			if (!found && hit_s2[i]) begin
				found = 1'b1;
				k     = 3'(i);
			end
		end
		for (int i = 0; i < 7; i++) begin
			if (!sfound && (4'(i + 1) < npts) && ge_s2[i] && le_s2[i+1]) begin
				sfound = 1'b1;
				sj     = 3'(i);
			end
		end
		ahk = ah_s2[k];
		u   = x17 - px17[k];
		vt  = $signed({5'b00000, ahk}) - $signed({u[16], u, 1'b0});
		wt  = $signed({5'b00000, ahk}) + $signed({u[16], u, 1'b0});

		knee_c = 1'b0;
		base_c = x_s2;
		a_c    = '0;
		b_c    = '0;
		d_c    = 17'sd1;
		e1_c   = $signed({py16[k][15], py16[k]}) - $signed({py16[k-1][15], py16[k-1]});
		e2_c   = $signed({py16[k+1][15], py16[k+1]}) - $signed({py16[k][15], py16[k]});
		dd     = px17[k] - px17[k-1];
		d1_c   = dd[15:0];
		dd     = px17[k+1] - px17[k];
		d2_c   = dd[15:0];
		v_c    = vt[14:0];
		w_c    = wt[14:0];
		ahk_c  = ahk;

		if (knee_q >= csk_pkg::KNEE_MIN && found && ahk > csk_pkg::KNEE_NARROW) begin
			knee_c = 1'b1;
			base_c = py16[k];
		end else if (npts == 4'd0) begin
			base_c = x_s2;
		end else if (npts == 4'd1 || le_s2[0]) begin
			base_c = py16[0];
		end else if (ge_s2[nm1]) begin
			base_c = py16[nm1];
			dd     = px17[nm1] - px17[nm2];
			if (dd != 0) begin
				a_c = x17 - px17[nm1];
				b_c = $signed({py16[nm1][15], py16[nm1]}) - $signed({py16[nm2][15], py16[nm2]});
				d_c = dd;
			end
		end else if (sfound) begin
			base_c = py16[sj];
			dd     = px17[3'(sj + 3'd1)] - px17[sj];
			if (dd > 0) begin
				a_c = x17 - px17[sj];
				b_c = $signed({py16[3'(sj + 3'd1)][15], py16[3'(sj + 3'd1)]})
					- $signed({py16[sj][15], py16[sj]});
				d_c = dd;
			end
		end else begin
			base_c = x_s2;
		end
	end

	logic               v_s3, knee_s3;
	logic signed [15:0] base_s3;
	logic signed [16:0] a_s3, b_s3, d_s3, e1_s3, e2_s3;
	logic [15:0]        d1_s3, d2_s3;
	logic [14:0]        v_s3_op, w_s3;
	logic [13:0]        ah_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			knee_s3 <= knee_c;
			base_s3 <= base_c;
			a_s3    <= a_c;
			b_s3    <= b_c;
			d_s3    <= d_c;
			e1_s3   <= e1_c;
			e2_s3   <= e2_c;
			d1_s3   <= d1_c;
			d2_s3   <= d2_c;
			v_s3_op <= v_c;
			w_s3    <= w_c;
			ah_s3   <= ahk_c;
		end
	end

	// Stage 3: first products.
	logic               v_s4, knee_s4;
	logic signed [15:0] base_s4;
	logic signed [33:0] p1_s4, p2_s4, lin_s4;
	logic [29:0]        vv_s4, ww_s4, ahd1_s4;
	logic [15:0]        d2_s4;
	logic signed [16:0] d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			knee_s4 <= knee_s3;
			base_s4 <= base_s3;
			p1_s4   <= e2_s3 * $signed({1'b0, d1_s3});
			p2_s4   <= e1_s3 * $signed({1'b0, d2_s3});
			lin_s4  <= a_s3 * b_s3;
			vv_s4   <= v_s3_op * v_s3_op;
			ww_s4   <= w_s3 * w_s3;
			ahd1_s4 <= ah_s3 * d1_s3;
			d2_s4   <= d2_s3;
			d_s4    <= d_s3;
		end
	end

	// Stage 4: second products.
	logic                               v_s5, knee_s5;
	logic signed [15:0]                 base_s5;
	logic signed [csk_pkg::NUM_W-1:0]   t1_s5, t2_s5;
	logic [csk_pkg::DEN_W-1:0]          denk_s5;
	logic signed [33:0]                 lin_s5;
	logic signed [16:0]                 d_s5;
	logic [45:0]                        dp_c;

	assign dp_c = ahd1_s4 * d2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			knee_s5 <= knee_s4;
			base_s5 <= base_s4;
			t1_s5   <= p1_s4 * $signed({1'b0, ww_s4});
			t2_s5   <= p2_s4 * $signed({1'b0, vv_s4});
			denk_s5 <= {dp_c, 3'b000};
			lin_s5  <= lin_s4;
			d_s5    <= d_s4;
		end
	end

	// Stage 5: numerator and denominator.
	logic                               v_s6, dneg_s6;
	logic signed [15:0]                 base_s6;
	logic signed [csk_pkg::NUM_W-1:0]   num_s6;
	logic [csk_pkg::DEN_W-1:0]          den_s6;
	logic [16:0]                        dabs_c;

	assign dabs_c = d_s5[16] ? 17'(-d_s5) : 17'(d_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s6 <= base_s5;
			num_s6  <= knee_s5 ? t1_s5 - t2_s5 : csk_pkg::NUM_W'(lin_s5);
			den_s6  <= knee_s5 ? denk_s5 : csk_pkg::DEN_W'(dabs_c);
			dneg_s6 <= !knee_s5 && d_s5[16];
		end
	end

	// Stage 6: sign and magnitude into the divider.
	logic [csk_pkg::NUM_W-1:0] nabs_c;
	csk_pkg::div_side_t        side_c, side_d;
	logic                      dv_valid, rem_nz;
	logic [csk_pkg::QUO_W-1:0] quo;

	assign nabs_c = num_s6[csk_pkg::NUM_W-1] ? csk_pkg::NUM_W'(-num_s6)
	                                         : csk_pkg::NUM_W'(num_s6);
	assign side_c = {base_s6, num_s6[csk_pkg::NUM_W-1] ^ dneg_s6};

	csk_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.mag       (nabs_c[csk_pkg::MAG_W-1:0]),
		.den       (den_s6),
		.side_in   (side_c),
		.out_valid (dv_valid),
		.quo       (quo),
		.rem_nz    (rem_nz),
		.side_out  (side_d)
	);

	// Final stage: truncate toward zero and saturate.
	logic signed [33:0] qs_c;
	logic signed [34:0] t_c, tc_c;
	logic signed [15:0] out_level_q;
	logic               sat_q;

	always_comb begin
		if (side_d.neg) begin
			qs_c = 34'sd0 - $signed({2'b00, quo}) - $signed({33'd0, rem_nz});
		end else begin
			qs_c = $signed({2'b00, quo});
		end
		t_c  = $signed({qs_c[33], qs_c}) + $signed({{19{side_d.base[15]}}, side_d.base});
		tc_c = (t_c[34] && rem_nz) ? t_c + 35'sd1 : t_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tc_c > 35'sd32767) begin
				out_level_q <= 16'sh7FFF;
				sat_q       <= 1'b1;
			end else if (tc_c < -35'sd32768) begin
				out_level_q <= 16'sh8000;
				sat_q       <= 1'b1;
			end else begin
				out_level_q <= tc_c[15:0];
				sat_q       <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign output_level = out_level_q;
	assign saturated    = sat_q;

endmodule

`default_nettype wire
